>>> sv/odpdr_pkg.sv
// Shared types, constants and the arctangent table for odometry dead reckoning.
package odpdr_pkg;

  // Iterations of each vectoring and rotation pass
  localparam int CordicSteps = 16;
  localparam int CntW        = $clog2(CordicSteps + 1);
  localparam int IdxW        = $clog2(CordicSteps);

  // Datapath width of the shared rotator, angle accumulator width
  localparam int DataW  = 56;
  localparam int AngW   = 34;
  localparam int OffW   = DataW - 16;

  // 1/K^2 in Q0.32
  localparam logic [31:0] GainSqInv = 32'd1583795545;

  typedef enum logic {
    CORDIC_VECTOR = 1'b0,
    CORDIC_ROTATE = 1'b1
  } cordic_mode_e;

  typedef struct packed {
    logic         start;
    cordic_mode_e mode;
  } cordic_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VEC,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_ROT_START,
    ST_ROT,
    ST_FIN,
    ST_OUT
  } state_e;

  // Arctangent of 2^-i in binary angle, 2^32 units per turn
  function automatic logic [31:0] atan_at(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

>>> sv/odpdr_if.sv
// Handshake channels for odometry requests and pose words.
interface odpdr_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic        [15:0] in_heading;

  modport source (output valid, kind, in_x, in_y, in_heading, input ready);
  modport sink   (input valid, kind, in_x, in_y, in_heading, output ready);
endinterface

interface odpdr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic        [15:0] pose_heading;

  modport source (output valid, pose_x, pose_y, pose_heading, input ready);
  modport sink   (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

>>> sv/odpdr_cordic.sv
// Shared CORDIC unit: one micro-rotation per cycle, vectoring or rotation mode.
module odpdr_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  odpdr_pkg::cordic_cmd_t            cmd_i,
  input  logic signed [odpdr_pkg::DataW-1:0] x_i,
  input  logic signed [odpdr_pkg::DataW-1:0] y_i,
  input  logic signed [odpdr_pkg::AngW-1:0]  z_i,
  output logic                              done_o,
  output logic signed [odpdr_pkg::DataW-1:0] x_o,
  output logic signed [odpdr_pkg::DataW-1:0] y_o,
  output logic signed [odpdr_pkg::AngW-1:0]  z_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [odpdr_pkg::CntW-1:0]         cnt_q, cnt_d;
  odpdr_pkg::cordic_mode_e            mode_q, mode_d;
  logic signed [odpdr_pkg::DataW-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [odpdr_pkg::AngW-1:0]  z_q, z_d, a;
  logic                               pos;

  // One micro-rotation step
  always_comb begin
    xs = x_q >>> cnt_q;
    ys = y_q >>> cnt_q;
    a  = odpdr_pkg::AngW'(odpdr_pkg::atan_at(5'(cnt_q[odpdr_pkg::IdxW-1:0])));
    pos = (mode_q == odpdr_pkg::CORDIC_VECTOR) ? !y_q[odpdr_pkg::DataW-1]
                                               : !z_q[odpdr_pkg::AngW-1];
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mode_d = mode_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      mode_d = cmd_i.mode;
      x_d = x_i;
      y_d = y_i;
      z_d = z_i;
    end else if (busy_q) begin
      if ((mode_q == odpdr_pkg::CORDIC_VECTOR) == pos) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
      end
      // vectoring accumulates the angle, rotation drives it to zero
      if ((mode_q == odpdr_pkg::CORDIC_VECTOR) == pos) z_d = z_q + a;
      else                                             z_d = z_q - a;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == odpdr_pkg::CntW'(odpdr_pkg::CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= odpdr_pkg::CORDIC_VECTOR;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

>>> sv/odometry_pose_dead_reckoning.sv
// Odometry dead reckoning: an odometry sample with motion runs one 16-step CORDIC
// vectoring pass and one 16-step rotation pass on the same shared CORDIC unit, with the
// high and low gain multiplies and the rotation setup between them and the pose update
// after them. Its pose word is presented as the sequencer returns to idle, so the next
// request can be taken while that word is presented. A sample with no motion skips both
// passes and goes to the pose update, and a pose load skips all arithmetic. A pose word
// that is not taken holds the sequencer in its output state until the word is taken.
// One request is in flight at a time; a new request is taken once the sequencer is idle,
// even while the previous pose word still waits at the output register.
module odometry_pose_dead_reckoning (
  input  logic           clk_i,
  input  logic           rst_ni,
  odpdr_in_if.sink       in_i,
  odpdr_out_if.source    out_o
);

  localparam int DW = odpdr_pkg::DataW;
  localparam int AW = odpdr_pkg::AngW;
  localparam int OW = odpdr_pkg::OffW;

  odpdr_pkg::state_e      state_q, state_d;
  odpdr_pkg::cordic_cmd_t cmd;
  logic signed [DW-1:0]   cx_in, cy_in, cx_out, cy_out;
  logic signed [AW-1:0]   cz_in, cz_out;
  logic                   c_done;

  logic signed [31:0] last_x_q, last_y_q, bel_x_q, bel_y_q;
  logic        [15:0] last_h_q, bel_h_q;
  logic signed [31:0] ix_q, iy_q;
  logic        [15:0] ih_q;
  logic        [31:0] ang_q;
  logic        [DW-1:0] mag_q;
  logic        [DW-1:0] phi_q;
  logic        [31:0] plo_q;
  logic signed [OW-1:0] offx_q, offy_q;
  logic signed [31:0] px_q, py_q;
  logic        [15:0] ph_q;
  logic               ov_q;

  logic               accept, upd_out;
  logic signed [32:0] dx, dy;
  logic signed [DW-1:0] x0, y0;
  logic        [DW-1:0] len;
  logic        [31:0] dir;
  logic signed [40:0] sx, sy;
  logic signed [DW-1:0] rx, ry;

  odpdr_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .x_i    (cx_in),
    .y_i    (cy_in),
    .z_i    (cz_in),
    .done_o (c_done),
    .x_o    (cx_out),
    .y_o    (cy_out),
    .z_o    (cz_out)
  );

  assign in_i.ready = (state_q == odpdr_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign upd_out    = (state_q == odpdr_pkg::ST_OUT) && (!ov_q || out_o.ready);

  // Displacement against the previous sample scaled by 2^16, gain-corrected length, direction and offsets
  always_comb begin
    dx  = 33'(in_i.in_x) - 33'(last_x_q);
    dy  = 33'(in_i.in_y) - 33'(last_y_q);
    x0  = DW'(dx) <<< 16;
    y0  = DW'(dy) <<< 16;
    len = phi_q + DW'(plo_q);
    dir = {bel_h_q, 16'h0} + ang_q - {last_h_q, 16'h0};
    rx  = cx_out + DW'(32768);
    ry  = cy_out + DW'(32768);
    sx  = 41'(bel_x_q) + 41'(offx_q);
    sy  = 41'(bel_y_q) + 41'(offy_q);
  end

  // Sequencer and CORDIC command
  always_comb begin
    state_d    = state_q;
    cmd.start  = 1'b0;
    cmd.mode   = odpdr_pkg::CORDIC_VECTOR;
    cx_in      = x0;
    cy_in      = y0;
    cz_in      = '0;
    unique case (state_q)
      odpdr_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_i.kind) begin
            state_d = odpdr_pkg::ST_OUT;
          end else if (dx == '0 && dy == '0) begin
            state_d = odpdr_pkg::ST_FIN;
          end else begin
            cmd.start = 1'b1;
            state_d   = odpdr_pkg::ST_VEC;
            // fold the left half plane over by half a turn
            if (dx[32]) begin
              cx_in = -x0;
              cy_in = -y0;
              cz_in = AW'(32'h80000000);
            end
          end
        end
      end
      odpdr_pkg::ST_VEC:    if (c_done) state_d = odpdr_pkg::ST_MUL_HI;
      odpdr_pkg::ST_MUL_HI: state_d = odpdr_pkg::ST_MUL_LO;
      odpdr_pkg::ST_MUL_LO: state_d = odpdr_pkg::ST_ROT_START;
      odpdr_pkg::ST_ROT_START: begin
        cmd.start = 1'b1;
        cmd.mode  = odpdr_pkg::CORDIC_ROTATE;
        cy_in     = '0;
        // fold the back half of directions over by half a turn
        if (dir[31] != dir[30]) begin
          cx_in = -$signed(len);
          cz_in = AW'($signed({~dir[31], dir[30:0]}));
        end else begin
          cx_in = $signed(len);
          cz_in = AW'($signed(dir));
        end
        state_d = odpdr_pkg::ST_ROT;
      end
      odpdr_pkg::ST_ROT: if (c_done) state_d = odpdr_pkg::ST_FIN;
      odpdr_pkg::ST_FIN: state_d = odpdr_pkg::ST_OUT;
      odpdr_pkg::ST_OUT: if (upd_out) state_d = odpdr_pkg::ST_IDLE;
      default: state_d = odpdr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= odpdr_pkg::ST_IDLE;
      ov_q     <= 1'b0;
      last_x_q <= '0;
      last_y_q <= '0;
      last_h_q <= '0;
      bel_x_q  <= '0;
      bel_y_q  <= '0;
      bel_h_q  <= '0;
    end else begin
      state_q <= state_d;
      // hold the pose word until taken
      if (upd_out)           ov_q <= 1'b1;
      else if (out_o.ready)  ov_q <= 1'b0;
      if (accept && in_i.kind) begin
        bel_x_q <= in_i.in_x;
        bel_y_q <= in_i.in_y;
        bel_h_q <= in_i.in_heading;
      end
      // apply the motion, saturating the position
      if (state_q == odpdr_pkg::ST_FIN) begin
        if (sx > 41'sd2147483647)       bel_x_q <= 32'h7FFFFFFF;
        else if (sx < -41'sd2147483648) bel_x_q <= 32'h80000000;
        else                            bel_x_q <= sx[31:0];
        if (sy > 41'sd2147483647)       bel_y_q <= 32'h7FFFFFFF;
        else if (sy < -41'sd2147483648) bel_y_q <= 32'h80000000;
        else                            bel_y_q <= sy[31:0];
        bel_h_q  <= bel_h_q + ih_q - last_h_q;
        last_x_q <= ix_q;
        last_y_q <= iy_q;
        last_h_q <= ih_q;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ix_q   <= in_i.in_x;
      iy_q   <= in_i.in_y;
      ih_q   <= in_i.in_heading;
      offx_q <= '0;
      offy_q <= '0;
    end
    if (state_q == odpdr_pkg::ST_VEC && c_done) begin
      ang_q <= cz_out[31:0];
      mag_q <= cx_out[DW-1] ? '0 : cx_out;
    end
    if (state_q == odpdr_pkg::ST_MUL_HI) begin
      phi_q <= DW'(mag_q[DW-1:32]) * DW'(odpdr_pkg::GainSqInv);
    end
    if (state_q == odpdr_pkg::ST_MUL_LO) begin
      plo_q <= 32'((64'(mag_q[31:0]) * 64'(odpdr_pkg::GainSqInv)) >> 32);
    end
    if (state_q == odpdr_pkg::ST_ROT && c_done) begin
      offx_q <= OW'(rx >>> 16);
      offy_q <= OW'(ry >>> 16);
    end
    if (upd_out) begin
      px_q <= bel_x_q;
      py_q <= bel_y_q;
      ph_q <= bel_h_q;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.pose_x       = px_q;
  assign out_o.pose_y       = py_q;
  assign out_o.pose_heading = ph_q;

endmodule

>>> tb/sv/odometry_pose_dead_reckoning_test.sv
// Testbench for odometry dead reckoning: directed and random odometry and pose-load words with checked poses.
module odometry_pose_dead_reckoning_test;

  typedef struct {
    logic               kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [15:0] h;
  } request_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [15:0] h;
  } pose_t;

  localparam logic KindOdom = 1'b0;
  localparam logic KindLoad = 1'b1;
  localparam int WatchLimit = 2000;

  logic clk_i;
  logic rst_ni;

  odpdr_in_if  req_ch ();
  odpdr_out_if pose_ch ();

  odometry_pose_dead_reckoning dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch.sink),
    .out_o  (pose_ch.source)
  );

  // Own copy of the odometry and believed pose state
  logic signed [31:0] prev_x, prev_y, bel_x, bel_y;
  logic        [15:0] prev_h, bel_h;

  request_t pending_q[$];
  pose_t    pose_q[$];
  int       errors;
  int       n_odom, n_load, n_poses;
  bit       quiet_tail;
  bit       stim_done;

  // Floor shift of a signed 64-bit value
  function automatic longint fshr(input longint v, input int n);
    return v >>> n;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Advance the believed pose by one request and return the pose word it yields
  function automatic pose_t predict_pose(input request_t r);
    longint     vx, vy, tx, ty, z, offx, offy;
    logic [31:0] ang, dir, step_ang;
    logic [63:0] mag, len;
    pose_t       p;
    offx = 0;
    offy = 0;
    if (r.kind == KindLoad) begin
      bel_x = r.x;
      bel_y = r.y;
      bel_h = r.h;
    end else begin
      vx = (longint'(r.x) - longint'(prev_x)) * 65536;
      vy = (longint'(r.y) - longint'(prev_y)) * 65536;
      ang = 0;
      if (vx != 0 || vy != 0) begin
        if (vx < 0) begin
          vx = -vx;
          vy = -vy;
          ang = 32'h80000000;
        end
        for (int i = 0; i < odpdr_pkg::CordicSteps; i++) begin
          step_ang = odpdr_pkg::atan_at(i[4:0]);
          if (vy >= 0) begin
            tx = vx + fshr(vy, i); ty = vy - fshr(vx, i); ang = ang + step_ang;
          end else begin
            tx = vx - fshr(vy, i); ty = vy + fshr(vx, i); ang = ang - step_ang;
          end
          vx = tx;
          vy = ty;
        end
        mag = (vx < 0) ? 64'd0 : 64'(vx);
        len = (mag >> 32) * 64'(odpdr_pkg::GainSqInv)
            + (((mag & 64'hffffffff) * 64'(odpdr_pkg::GainSqInv)) >> 32);
        dir = {bel_h, 16'h0} + (ang - {prev_h, 16'h0});
        vx = longint'(len);
        vy = 0;
        if (dir[31:30] == 2'd1 || dir[31:30] == 2'd2) begin
          vx = -vx;
          dir = dir - 32'h80000000;
        end
        z = longint'($signed(dir));
        for (int i = 0; i < odpdr_pkg::CordicSteps; i++) begin
          step_ang = odpdr_pkg::atan_at(i[4:0]);
          if (z >= 0) begin
            tx = vx - fshr(vy, i); ty = vy + fshr(vx, i); z = z - longint'(step_ang);
          end else begin
            tx = vx + fshr(vy, i); ty = vy - fshr(vx, i); z = z + longint'(step_ang);
          end
          vx = tx;
          vy = ty;
        end
        offx = fshr(vx + 32768, 16);
        offy = fshr(vy + 32768, 16);
      end
      bel_x = clamp32(longint'(bel_x) + offx);
      bel_y = clamp32(longint'(bel_y) + offy);
      bel_h = bel_h + r.h - prev_h;
      prev_x = r.x;
      prev_y = r.y;
      prev_h = r.h;
    end
    p.x = bel_x;
    p.y = bel_y;
    p.h = bel_h;
    return p;
  endfunction

  function automatic request_t mk_req(input logic k, input logic [31:0] x,
                                      input logic [31:0] y, input logic [15:0] h);
    request_t r;
    r.kind = k;
    r.x = x;
    r.y = y;
    r.h = h;
    return r;
  endfunction

  // Clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Driver: present pending words, idle in random bursts
  int src_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        if (pending_q[0].kind == KindLoad) n_load <= n_load + 1;
        else                               n_odom <= n_odom + 1;
        pose_q.push_back(predict_pose(pending_q.pop_front()));
      end
      if (req_ch.valid && !req_ch.ready) begin
        // hold the current word
      end else if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        src_gap <= $urandom_range(1, 18);
        req_ch.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= pending_q[0].kind;
        req_ch.in_x       <= pending_q[0].x;
        req_ch.in_y       <= pending_q[0].y;
        req_ch.in_heading <= pending_q[0].h;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: stall at random, check each pose word against the oldest prediction
  int snk_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_ch.ready <= 1'b0;
      snk_gap <= 0;
    end else begin
      if (pose_ch.valid && pose_ch.ready) begin
        n_poses <= n_poses + 1;
        if (pose_q.size() == 0) begin
          $error("pose word with no prediction waiting");
          errors = errors + 1;
        end else begin
          pose_t e;
          e = pose_q.pop_front();
          if (pose_ch.pose_x !== e.x) begin
            $error("pose_x expected %0d actual %0d", e.x, pose_ch.pose_x);
            errors = errors + 1;
          end
          if (pose_ch.pose_y !== e.y) begin
            $error("pose_y expected %0d actual %0d", e.y, pose_ch.pose_y);
            errors = errors + 1;
          end
          if (pose_ch.pose_heading !== e.h) begin
            $error("pose_heading expected %0d actual %0d", e.h, pose_ch.pose_heading);
            errors = errors + 1;
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        pose_ch.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        snk_gap <= $urandom_range(1, 18);
        pose_ch.ready <= 1'b0;
      end else begin
        pose_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles without any accepted word
  int idle_cycles;
  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (pose_ch.valid && pose_ch.ready)
        || (stim_done && pending_q.size() == 0 && pose_q.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rnd_pos(input int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
      default: return $urandom_range(0, 32'h3ff) - 32'h200;
    endcase
  endfunction

  initial begin
    logic [31:0] ox, oy;
    logic [15:0] oh;
    int mode;
    rst_ni = 1'b0;
    errors = 0;
    n_odom = 0;
    n_load = 0;
    n_poses = 0;
    quiet_tail = 0;
    stim_done = 0;
    prev_x = 0; prev_y = 0; prev_h = 0;
    bel_x = 0; bel_y = 0; bel_h = 0;
    req_ch.valid = 1'b0;
    req_ch.kind = 1'b0;
    req_ch.in_x = '0;
    req_ch.in_y = '0;
    req_ch.in_heading = '0;
    pose_ch.ready = 1'b0;

    // Directed: first sample from the zero pose, zero motion, extremes, saturation
    pending_q.push_back(mk_req(KindOdom, 32'h00010000, 32'h00020000, 16'h1000));
    pending_q.push_back(mk_req(KindOdom, 32'h00010000, 32'h00020000, 16'h2000));
    pending_q.push_back(mk_req(KindOdom, 32'h7fffffff, 32'h7fffffff, 16'hffff));
    pending_q.push_back(mk_req(KindOdom, 32'h80000000, 32'h80000000, 16'h0000));
    pending_q.push_back(mk_req(KindOdom, 32'h7fffffff, 32'h80000000, 16'h8000));
    pending_q.push_back(mk_req(KindLoad, 32'h7fff0000, 32'h7fff0000, 16'h0000));
    pending_q.push_back(mk_req(KindOdom, 32'h7fffffff, 32'h7fffffff, 16'h8000));
    pending_q.push_back(mk_req(KindLoad, 32'h80000000, 32'h80000000, 16'hffff));
    pending_q.push_back(mk_req(KindOdom, 32'h80000000, 32'h80000000, 16'h4000));
    pending_q.push_back(mk_req(KindOdom, 32'h80000000, 32'h7fffffff, 16'hc000));
    pending_q.push_back(mk_req(KindLoad, 32'h7fffffff, 32'h80000000, 16'h8000));
    pending_q.push_back(mk_req(KindLoad, 32'h00000000, 32'h00000000, 16'h0000));
    pending_q.push_back(mk_req(KindOdom, 32'h00000000, 32'h00000000, 16'h0000));
    pending_q.push_back(mk_req(KindOdom, 32'hffffffff, 32'h00000000, 16'h0001));
    pending_q.push_back(mk_req(KindOdom, 32'hffffffff, 32'h00000001, 16'h7fff));
    pending_q.push_back(mk_req(KindOdom, 32'h00000000, 32'hffffffff, 16'h5555));
    pending_q.push_back(mk_req(KindOdom, 32'haaaaaaaa, 32'h55555555, 16'haaaa));

    // Random: mostly small smooth trajectories, some wide jumps and loads
    ox = 0; oy = 0; oh = 0;
    for (int i = 0; i < 1450; i++) begin
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        pending_q.push_back(mk_req(KindLoad, $urandom(), $urandom(), 16'($urandom())));
      end else begin
        if (mode == 1) begin
          ox = $urandom(); oy = $urandom(); oh = 16'($urandom());
        end else begin
          ox = ox + rnd_pos(mode < 6 ? 1 : 2);
          oy = oy + rnd_pos(mode < 6 ? 1 : 2);
          oh = 16'(oh + $urandom_range(0, 16'h0fff) - 16'h0800);
        end
        pending_q.push_back(mk_req(KindOdom, ox, oy, oh));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drop idling for the last stretch of the run
    while (pending_q.size() >= 150) @(posedge clk_i);
    quiet_tail = 1;
    while (pending_q.size() != 0 || req_ch.valid) @(posedge clk_i);
    stim_done = 1;
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Checked %0d pose words from %0d odometry samples and %0d pose loads,",
             n_poses, n_odom, n_load);
    $display("with random idling on both channels and saturating extremes.");
    if (errors == 0 && pose_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> odometry_pose_dead_reckoning.f
sv/odpdr_pkg.sv
sv/odpdr_if.sv
sv/odpdr_cordic.sv
sv/odometry_pose_dead_reckoning.sv
tb/sv/odometry_pose_dead_reckoning_test.sv
